### rtl/trh_pkg.sv
`timescale 1ns / 1ps

package trh_pkg;

  // ring depth, a power of two so that a slot is the low bits of a stamp
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned FILL_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_RESTART = 2'd3
  } req_code_t;

  typedef logic [STAMP_W-1:0]         stamp_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [FILL_W-1:0]          fill_t;

endpackage

### rtl/trh_if.sv
`timescale 1ns / 1ps

interface trh_req_if import trh_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  stamp_t      stamp;
  sample_t     sample_in;

  modport source (output valid, output req_type, output stamp, output sample_in,
                  input ready);
  modport sink   (input valid, input req_type, input stamp, input sample_in,
                  output ready);
endinterface

interface trh_res_if import trh_pkg::*;;
  logic        valid;
  logic        ready;
  sample_t     sample_out;
  logic        out_of_range;
  stamp_t      assigned_stamp;
  stamp_t      lowest_stamp;
  stamp_t      next_stamp;

  modport source (output valid, output sample_out, output out_of_range,
                  output assigned_stamp, output lowest_stamp, output next_stamp,
                  input ready);
  modport sink   (input valid, input sample_out, input out_of_range,
                  input assigned_stamp, input lowest_stamp, input next_stamp,
                  output ready);
endinterface

### rtl/timestamped_ring_history.sv
`timescale 1ns / 1ps

// Sample history addressed by absolute timestamp. Requests append a sample at
// the next stamp, read or overwrite a stamp inside the retained window, or
// restart the window empty at a given stamp. The block takes one request per
// cycle while results are taken, and its result appears in the cycle after
// acceptance; that rate is set by the single-port sample memory, which sees
// exactly one access per request. A stalled result holds the request side
// until it is taken. The memory is not cleared at reset: only stamps inside
// the window are read, and those slots have always been written. Stamps do
// not wrap: a window crossing 2^32 is not supported.
module timestamped_ring_history import trh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  trh_req_if.sink   req,
  trh_res_if.source res
);

  sample_t mem [DEPTH];

  stamp_t  oldest_stamp, oldest_stamp_next;
  stamp_t  end_stamp, end_stamp_next;
  fill_t   fill_count, fill_count_next;

  logic    res_valid;
  logic    rd_ok;
  sample_t rd_data;
  logic    oor, oor_next;
  stamp_t  assigned, assigned_next;
  stamp_t  lowest, next_out;

  logic    accept;
  logic    in_window;
  logic    mem_we;
  logic    rd_ok_next;
  addr_t   mem_addr;
  req_code_t code;

  assign req.ready = !rst && (!res_valid || res.ready);
  assign accept    = req.valid && req.ready;
  assign code      = req_code_t'(req.req_type);
  assign in_window = (req.stamp >= oldest_stamp) && (req.stamp < end_stamp);

  always_comb begin
    oldest_stamp_next = oldest_stamp;
    end_stamp_next    = end_stamp;
    fill_count_next   = fill_count;
    oor_next          = 1'b0;
    assigned_next     = '0;
    rd_ok_next        = 1'b0;
    mem_we            = 1'b0;
    mem_addr          = req.stamp[ADDR_W-1:0];
    case (code)
      REQ_APPEND: begin
        mem_addr       = end_stamp[ADDR_W-1:0];
        mem_we         = 1'b1;
        assigned_next  = end_stamp;
        end_stamp_next = end_stamp + STAMP_W'(1);
        if (fill_count >= FILL_W'(DEPTH)) begin
          // full ring drops the oldest sample
          oldest_stamp_next = oldest_stamp + STAMP_W'(1);
        end else begin
          fill_count_next = fill_count + FILL_W'(1);
        end
      end
      REQ_READ: begin
        rd_ok_next = in_window;
        oor_next   = !in_window;
      end
      REQ_WRITE: begin
        mem_we   = in_window;
        oor_next = !in_window;
      end
      REQ_RESTART: begin
        oldest_stamp_next = req.stamp;
        end_stamp_next    = req.stamp;
        fill_count_next   = '0;
      end
      default: begin
        oor_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (mem_we) begin
        mem[mem_addr] <= req.sample_in;
      end
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_stamp <= '0;
      end_stamp    <= '0;
      fill_count   <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        oldest_stamp <= oldest_stamp_next;
        end_stamp    <= end_stamp_next;
        fill_count   <= fill_count_next;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok    <= rd_ok_next;
      oor      <= oor_next;
      assigned <= assigned_next;
      lowest   <= oldest_stamp_next;
      next_out <= end_stamp_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.sample_out     = rd_ok ? rd_data : '0;
  assign res.out_of_range   = oor;
  assign res.assigned_stamp = assigned;
  assign res.lowest_stamp   = lowest;
  assign res.next_stamp     = next_out;

  // window span always matches the fill count
  a_span_matches_fill: assert property (@(posedge clk) disable iff (rst)
    (end_stamp - oldest_stamp) == STAMP_W'(fill_count))
    else $error("window span differs from fill count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(DEPTH))
    else $error("fill count above depth");

  a_append_stamp: assert property (@(posedge clk) disable iff (rst)
    accept && code == REQ_APPEND |=>
      res.assigned_stamp == $past(end_stamp) &&
      res.next_stamp == res.assigned_stamp + STAMP_W'(1))
    else $error("append result stamps wrong");

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.out_of_range |->
      res.sample_out == '0 && res.assigned_stamp == '0)
    else $error("out of range result carries data");

endmodule
